FILE: src/string_key_hash_set_assert.svh
// Assertion macros for the string key hash set checker
`ifndef STRING_KEY_HASH_SET_ASSERT_SVH
`define STRING_KEY_HASH_SET_ASSERT_SVH

`define SSH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssh check failed");

`define SSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssh check failed");

`endif

FILE: src/ssh_pkg.sv
// Shared types and constants of the string key hash set
`timescale 1ns / 1ps
package ssh_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int KEY_BYTES     = 32;
    localparam int KEY_WORDS     = (KEY_BYTES + 7) / 8;
    localparam int KW_W          = $clog2(KEY_WORDS);
    localparam int LEN_W         = 6;
    localparam int ADDR_W        = SLOT_W + KW_W;

    localparam logic [31:0] HASH_SEED = 32'd12345;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOOLONG  = 2'd3
    } t_status;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  slot_index;
    } t_out_item;
endpackage

FILE: src/string_key_hash_set.sv
// String key hash set: MurmurHash3 x86_32 with linear probing
// Each key word is accepted, then S_MUL1, S_MUL2, S_MIX (one shared 32x32 multiplier).
// A final word then adds S_FIN0, S_FM1, S_FM2, S_FX, plus S_PRD and S_PCHK per probed
// slot, S_KRD/S_KCMP per further word on a length match, S_STORE per word on add.
// One word in flight at a time; the result register holds until taken.
// Synchronous active-low reset empties the table via per-slot valid flops at once.
`timescale 1ns / 1ps
module string_key_hash_set (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ssh_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ssh_pkg::t_out_item o_out_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MIX, S_FIN0, S_FM1, S_FM2, S_FX,
        S_PRD, S_PCHK, S_KRD, S_KCMP, S_STORE, S_OUT
    } t_state;

    t_state                        r_state;
    logic [63:0]                   r_pkey [ssh_pkg::KEY_WORDS];
    logic [ssh_pkg::LEN_W-1:0]     r_len;
    logic                          r_too_long;
    logic                          r_req;
    logic [31:0]                   r_h;
    logic [31:0]                   r_k;
    logic [31:0]                   r_word;
    logic [2:0]                    r_n;
    logic                          r_last;
    logic [ssh_pkg::SLOT_W-1:0]    r_slot;
    logic [ssh_pkg::SLOT_W-1:0]    r_cnt;
    logic [ssh_pkg::KW_W-1:0]      r_w;
    logic [ssh_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic                          r_out_valid;
    ssh_pkg::t_out_item            r_out;

    logic [2:0]                    in_n;
    logic [31:0]                   in_word;
    logic [6:0]                    new_len;
    logic [31:0]                   mul_a, mul_b, mul_p;
    logic [31:0]                   mix_x, fin_t, fm2_t, fx_t;
    logic [ssh_pkg::KW_W-1:0]      rd_w;
    logic [ssh_pkg::ADDR_W-1:0]    key_raddr, key_waddr;
    logic [63:0]                   key_rdata;
    logic [ssh_pkg::LEN_W-1:0]     len_rdata, len_eff;
    logic                          key_we, len_we, at_end;

    always_comb begin
        in_n = (i_in_data.word_bytes > 3'd4) ? 3'd4 : i_in_data.word_bytes;
        for (int b = 0; b < 4; b++) begin
            in_word[8*b +: 8] = (3'(b) < in_n) ? i_in_data.key_word[8*b +: 8] : 8'h00;
        end
        new_len = {1'b0, r_len} + {4'b0, in_n};
    end

    always_comb begin
        mul_a = r_word;
        mul_b = ssh_pkg::C1;
        unique case (r_state)
            S_MUL2: begin
                mul_a = {r_k[16:0], r_k[31:17]};
                mul_b = ssh_pkg::C2;
            end
            S_FM1: begin
                mul_a = r_h;
                mul_b = ssh_pkg::F1;
            end
            S_FM2: begin
                mul_a = fm2_t;
                mul_b = ssh_pkg::F2;
            end
            default: begin
                mul_a = r_word;
                mul_b = ssh_pkg::C1;
            end
        endcase
    end

    assign mul_p = 32'(mul_a * mul_b);
    assign mix_x = r_h ^ r_k;
    assign fin_t = r_h ^ {26'b0, r_len};
    assign fm2_t = r_h ^ (r_h >> 13);
    assign fx_t  = r_h ^ (r_h >> 16);

    assign rd_w      = (r_state == S_PRD) ? '0 : r_w;
    assign key_raddr = {r_slot, rd_w};
    assign key_waddr = {r_slot, r_w};
    assign key_we    = (r_state == S_STORE);
    assign len_we    = (r_state == S_STORE) && (r_w == '0);
    assign len_eff   = r_valid[r_slot] ? len_rdata : '0;
    assign at_end    = (r_cnt == {ssh_pkg::SLOT_W{1'b1}});

    ssh_ram #(.WIDTH(64), .DEPTH(ssh_pkg::TABLE_ENTRIES * ssh_pkg::KEY_WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_pkey[r_w]),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    ssh_ram #(.WIDTH(ssh_pkg::LEN_W), .DEPTH(ssh_pkg::TABLE_ENTRIES)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_slot),
        .i_wdata (r_len),
        .i_raddr (r_slot),
        .o_rdata (len_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_len       <= '0;
            r_too_long  <= 1'b0;
            r_req       <= 1'b0;
            r_h         <= ssh_pkg::HASH_SEED;
            for (int i = 0; i < ssh_pkg::KEY_WORDS; i++) begin
                r_pkey[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_word <= in_word;
                        r_n    <= in_n;
                        r_last <= i_in_data.last_word || (in_n != 3'd4);
                        if (r_len == '0 && !r_too_long) begin
                            r_req <= i_in_data.req_type;
                        end
                        if (!r_too_long) begin
                            if (new_len > 7'(ssh_pkg::KEY_BYTES)) begin
                                r_too_long <= 1'b1;
                            end else begin
                                if (r_len[5:3] < 3'(ssh_pkg::KEY_WORDS)) begin
                                    r_pkey[r_len[3 +: ssh_pkg::KW_W]] <=
                                        r_pkey[r_len[3 +: ssh_pkg::KW_W]] |
                                        ({32'b0, in_word} << (r_len[2] ? 32 : 0));
                                end
                                r_len <= new_len[ssh_pkg::LEN_W-1:0];
                            end
                        end
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_k     <= mul_p;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_k     <= mul_p;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (r_n == 3'd4) begin
                        r_h <= ({mix_x[18:0], mix_x[31:19]} << 2) +
                               {mix_x[18:0], mix_x[31:19]} + ssh_pkg::C3;
                    end else if (r_n != 3'd0) begin
                        r_h <= mix_x;
                    end
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_too_long) begin
                        r_out       <= '{status: ssh_pkg::ST_TOOLONG, slot_index: 8'd0};
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (r_len == '0) begin
                        r_out       <= '{status: (r_req ? ssh_pkg::ST_OK : ssh_pkg::ST_NOTFOUND),
                                         slot_index: 8'd0};
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_FIN0;
                    end
                end
                S_FIN0: begin
                    r_h     <= fin_t ^ (fin_t >> 16);
                    r_state <= S_FM1;
                end
                S_FM1: begin
                    r_h     <= mul_p;
                    r_state <= S_FM2;
                end
                S_FM2: begin
                    r_h     <= mul_p;
                    r_state <= S_FX;
                end
                S_FX: begin
                    r_slot  <= fx_t[ssh_pkg::SLOT_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (len_eff == '0) begin
                        if (r_req) begin
                            r_w     <= '0;
                            r_state <= S_STORE;
                        end else begin
                            r_out       <= '{status: ssh_pkg::ST_NOTFOUND, slot_index: 8'(r_slot)};
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end else if (len_eff != r_len || key_rdata != r_pkey[0]) begin
                        if (at_end) begin
                            r_out       <= '{status: (r_req ? ssh_pkg::ST_FULL : ssh_pkg::ST_NOTFOUND),
                                             slot_index: 8'(r_slot)};
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_PRD;
                        end
                    end else begin
                        r_w     <= ssh_pkg::KW_W'(1);
                        r_state <= S_KRD;
                    end
                end
                S_KRD: begin
                    r_state <= S_KCMP;
                end
                S_KCMP: begin
                    if (key_rdata != r_pkey[r_w]) begin
                        if (at_end) begin
                            r_out       <= '{status: (r_req ? ssh_pkg::ST_FULL : ssh_pkg::ST_NOTFOUND),
                                             slot_index: 8'(r_slot)};
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_PRD;
                        end
                    end else if (r_w == ssh_pkg::KW_W'(ssh_pkg::KEY_WORDS - 1)) begin
                        r_out       <= '{status: ssh_pkg::ST_OK, slot_index: 8'(r_slot)};
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_w     <= r_w + 1'b1;
                        r_state <= S_KRD;
                    end
                end
                S_STORE: begin
                    if (r_w == '0) begin
                        r_valid[r_slot] <= 1'b1;
                    end
                    if (r_w == ssh_pkg::KW_W'(ssh_pkg::KEY_WORDS - 1)) begin
                        r_out       <= '{status: ssh_pkg::ST_OK, slot_index: 8'(r_slot)};
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_len       <= '0;
                        r_too_long  <= 1'b0;
                        r_req       <= 1'b0;
                        r_h         <= ssh_pkg::HASH_SEED;
                        for (int i = 0; i < ssh_pkg::KEY_WORDS; i++) begin
                            r_pkey[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: src/ssh_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module ssh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/ssh_checker.sv
// Port-level checker for the string key hash set, bound to the top level
`timescale 1ns / 1ps
`include "string_key_hash_set_assert.svh"
module ssh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ssh_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ssh_pkg::t_out_item o_out_data
);
    `SSH_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `SSH_ASSERT_NOW(a_busy_with_result, o_out_valid, o_in_stall)
    `SSH_ASSERT_NOW(a_toolong_slot, o_out_valid && o_out_data.status == ssh_pkg::ST_TOOLONG, o_out_data.slot_index == 8'd0)
    `SSH_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid)
endmodule

bind string_key_hash_set ssh_checker u_ssh_checker (.*);
